/* rtl/pidwg_pkg.sv */
// Shared types, widths and constants of the PID controller with windup guard.
`default_nettype none

package pidwg_pkg;

  localparam int TempW  = 16;  // signed Q8.8 temperatures
  localparam int GainW  = 16;  // unsigned Q8.8 gains
  localparam int ErrW   = 17;  // target minus measurement, exact
  localparam int SumW   = 32;  // error sum
  localparam int DriveW = 32;  // signed Q16.16 result
  localparam int LimW   = 23;  // clamp limit, at most 6553600
  localparam int MacAW  = GainW + 1;  // gain, zero-extended to signed
  localparam int MacBW  = 24;  // error, measurement change or clamped sum
  localparam int AccW   = 36;  // holds P + I - D without overflow
  localparam int DivCntW = $clog2(LimW + 1);

  // 100.0 in Q8.8 scaled by 256 again, so the quotient comes out in Q8.8
  localparam logic [LimW-1:0] WindupNum = 23'd6553600;

  typedef enum logic [1:0] {
    CfgPGain  = 2'd0,
    CfgIGain  = 2'd1,
    CfgDGain  = 2'd2,
    CfgTarget = 2'd3
  } cfg_reg_e;

  typedef enum logic [2:0] {
    StIdle,
    StDiv,
    StClamp,
    StInt,
    StDer,
    StFin,
    StOut
  } state_e;

  typedef struct packed {
    logic issue;  // a product enters the unit this cycle
    logic clr;    // start a new accumulation with this product
    logic sub;    // subtract this product
  } mac_ctl_t;

endpackage

`default_nettype wire

/* rtl/pidwg_div.sv */
// Restoring divider: windup numerator over the integral gain, one quotient bit per cycle.
`default_nettype none

module pidwg_div (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [pidwg_pkg::GainW-1:0]   divisor_i,
  output logic                               busy_o,
  output logic                               done_o,
  output logic [pidwg_pkg::LimW-1:0]         quot_o
);

  logic [pidwg_pkg::DivCntW-1:0] cnt_q, cnt_d;
  logic                          done_q, done_d;
  logic [pidwg_pkg::GainW-1:0]   rem_q, rem_d;
  logic [pidwg_pkg::LimW-1:0]    num_q, num_d;
  logic [pidwg_pkg::LimW-1:0]    quot_q, quot_d;
  logic [pidwg_pkg::GainW:0]     trial;
  logic [pidwg_pkg::GainW:0]     diff;
  logic                          fits;

  assign trial = {rem_q, num_q[pidwg_pkg::LimW-1]};
  assign diff  = trial - {1'b0, divisor_i};
  assign fits  = (trial >= {1'b0, divisor_i});

  always_comb begin
    cnt_d  = cnt_q;
    done_d = 1'b0;
    rem_d  = rem_q;
    num_d  = num_q;
    quot_d = quot_q;
    if (start_i) begin
      cnt_d  = pidwg_pkg::DivCntW'(pidwg_pkg::LimW);
      rem_d  = '0;
      num_d  = pidwg_pkg::WindupNum;
      quot_d = '0;
    end else if (cnt_q != '0) begin
      cnt_d  = cnt_q - 1'b1;
      done_d = (cnt_q == pidwg_pkg::DivCntW'(1));
      rem_d  = fits ? diff[pidwg_pkg::GainW-1:0] : trial[pidwg_pkg::GainW-1:0];
      num_d  = {num_q[pidwg_pkg::LimW-2:0], 1'b0};
      quot_d = {quot_q[pidwg_pkg::LimW-2:0], fits};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    num_q  <= num_d;
    quot_q <= quot_d;
  end

  assign busy_o = (cnt_q != '0);
  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

`default_nettype wire

/* rtl/pidwg_mac.sv */
// Shared multiply-accumulate unit: registered product, then add or subtract into the sum.
`default_nettype none

module pidwg_mac (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire pidwg_pkg::mac_ctl_t                ctl_i,
  input  wire logic signed [pidwg_pkg::MacAW-1:0] a_i,
  input  wire logic signed [pidwg_pkg::MacBW-1:0] b_i,
  output logic signed [pidwg_pkg::AccW-1:0]       acc_o
);

  logic signed [pidwg_pkg::MacAW+pidwg_pkg::MacBW-1:0] prod_full;
  logic signed [pidwg_pkg::AccW-1:0] prod_q;
  logic signed [pidwg_pkg::AccW-1:0] acc_q, acc_d;
  logic signed [pidwg_pkg::AccW-1:0] base;
  logic                              pend_q, clr_q, sub_q;

  assign prod_full = a_i * b_i;

  always_comb begin
    base  = clr_q ? '0 : acc_q;
    acc_d = sub_q ? (base - prod_q) : (base + prod_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
    end else begin
      pend_q <= ctl_i.issue;
    end
  end

  always_ff @(posedge clk_i) begin
    // product magnitudes stay below 2^34, so the low bits carry the full value
    prod_q <= prod_full[pidwg_pkg::AccW-1:0];
    clr_q  <= ctl_i.clr;
    sub_q  <= ctl_i.sub;
    if (pend_q) begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule

`default_nettype wire

/* rtl/pid_controller_windup_guard.sv */
// Top level of the PID temperature controller with integral windup clamp.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+------------------------------
//   cfg     | in        | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//   in      | in        | in_valid_i/in_ready_o   | measured_temperature_i
//   out     | out       | out_valid_o/out_ready_i | drive_value_o
//
// One sample runs from accept through five sequencer steps before the next accept: the
// P, I and D products go one after another into the single multiply-accumulate unit.
// The clamp limit is held once computed; the first sample after reset or after an
// integral gain write (with a nonzero gain) first waits for the bit-serial divider.
// A result waits in the output register; the sequencer holds in its last step while
// an earlier result is still not taken. Reset clears gains, target and state to zero.
`default_nettype none

module pid_controller_windup_guard (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [1:0]                          cfg_index_i,
  input  wire logic [15:0]                         cfg_data_i,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic signed [pidwg_pkg::TempW-1:0]  measured_temperature_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic signed [pidwg_pkg::DriveW-1:0]      drive_value_o
);

  localparam int SumW  = pidwg_pkg::SumW;
  localparam int ErrW  = pidwg_pkg::ErrW;
  localparam int MacBW = pidwg_pkg::MacBW;
  localparam int AccW  = pidwg_pkg::AccW;
  localparam int DrvW  = pidwg_pkg::DriveW;

  pidwg_pkg::state_e state_q, state_d;

  logic [pidwg_pkg::GainW-1:0]        pgain_q, igain_q, dgain_q;
  logic signed [pidwg_pkg::TempW-1:0] target_q;
  logic signed [SumW-1:0]             error_sum_q;
  logic signed [pidwg_pkg::TempW-1:0] prev_q, meas_q;
  logic signed [ErrW-1:0]             err_q, err_d;
  logic signed [SumW-1:0]             sum_q, sum_d;
  logic [pidwg_pkg::LimW-1:0]         lim_q;
  logic                               lim_vld_q;
  logic                               out_valid_q;
  logic signed [DrvW-1:0]             drive_q, drive_d;

  logic                               in_beat, cfg_beat, out_beat;
  logic                               div_start, div_busy, div_done;
  logic [pidwg_pkg::LimW-1:0]         div_quot;
  logic                               load_out;
  logic                               need_div;

  logic signed [SumW:0]               sum_wide;
  logic signed [SumW-1:0]             lim_s, neg_lim, clamped;
  logic signed [ErrW-1:0]             delta;

  pidwg_pkg::mac_ctl_t                mac_ctl;
  logic signed [pidwg_pkg::MacAW-1:0] mac_a;
  logic signed [MacBW-1:0]            mac_b;
  logic signed [AccW-1:0]             acc;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == pidwg_pkg::StIdle);
  assign in_beat     = in_valid_i & in_ready_o;
  assign cfg_beat    = cfg_valid_i & cfg_ready_o;
  assign out_beat    = out_valid_q & out_ready_i;
  assign need_div    = (igain_q != '0) && !lim_vld_q;

  // error and saturated running sum, formed on the input beat
  always_comb begin
    err_d    = $signed({target_q[pidwg_pkg::TempW-1], target_q})
             - $signed({measured_temperature_i[pidwg_pkg::TempW-1], measured_temperature_i});
    sum_wide = $signed({error_sum_q[SumW-1], error_sum_q})
             + $signed({{(SumW+1-ErrW){err_d[ErrW-1]}}, err_d});
    if (sum_wide[SumW] != sum_wide[SumW-1]) begin
      sum_d = sum_wide[SumW] ? $signed({1'b1, {(SumW-1){1'b0}}})
                             : $signed({1'b0, {(SumW-1){1'b1}}});
    end else begin
      sum_d = sum_wide[SumW-1:0];
    end
  end

  // windup clamp; skipped with a zero integral gain
  always_comb begin
    lim_s   = $signed({{(SumW-pidwg_pkg::LimW){1'b0}}, lim_q});
    neg_lim = -lim_s;
    clamped = sum_q;
    if (igain_q != '0) begin
      if (sum_q > lim_s) begin
        clamped = lim_s;
      end else if (sum_q < neg_lim) begin
        clamped = neg_lim;
      end
    end
  end

  assign delta = $signed({meas_q[pidwg_pkg::TempW-1], meas_q})
               - $signed({prev_q[pidwg_pkg::TempW-1], prev_q});

  // saturate the accumulated sum to the result width
  always_comb begin
    if (acc[AccW-1:DrvW-1] != {(AccW-DrvW+1){acc[AccW-1]}}) begin
      drive_d = acc[AccW-1] ? $signed({1'b1, {(DrvW-1){1'b0}}})
                            : $signed({1'b0, {(DrvW-1){1'b1}}});
    end else begin
      drive_d = acc[DrvW-1:0];
    end
  end

  // sequencer: next state and unit controls
  always_comb begin
    state_d   = state_q;
    div_start = 1'b0;
    load_out  = 1'b0;
    mac_ctl   = '0;
    mac_a     = '0;
    mac_b     = '0;
    unique case (state_q)
      pidwg_pkg::StIdle: begin
        if (in_beat) begin
          div_start = need_div;
          state_d   = need_div ? pidwg_pkg::StDiv : pidwg_pkg::StClamp;
        end
      end
      pidwg_pkg::StDiv: begin
        if (div_done) begin
          state_d = pidwg_pkg::StClamp;
        end
      end
      pidwg_pkg::StClamp: begin
        mac_ctl = '{issue: 1'b1, clr: 1'b1, sub: 1'b0};
        mac_a   = $signed({1'b0, pgain_q});
        mac_b   = $signed({{(MacBW-ErrW){err_q[ErrW-1]}}, err_q});
        state_d = pidwg_pkg::StInt;
      end
      pidwg_pkg::StInt: begin
        // the clamped sum fits the operand whenever the gain is nonzero
        mac_ctl = '{issue: 1'b1, clr: 1'b0, sub: 1'b0};
        mac_a   = $signed({1'b0, igain_q});
        mac_b   = error_sum_q[MacBW-1:0];
        state_d = pidwg_pkg::StDer;
      end
      pidwg_pkg::StDer: begin
        mac_ctl = '{issue: 1'b1, clr: 1'b0, sub: 1'b1};
        mac_a   = $signed({1'b0, dgain_q});
        mac_b   = $signed({{(MacBW-ErrW){delta[ErrW-1]}}, delta});
        state_d = pidwg_pkg::StFin;
      end
      pidwg_pkg::StFin: begin
        state_d = pidwg_pkg::StOut;
      end
      pidwg_pkg::StOut: begin
        // hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          state_d  = pidwg_pkg::StIdle;
        end
      end
      default: begin
        state_d = pidwg_pkg::StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pidwg_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pgain_q     <= '0;
      igain_q     <= '0;
      dgain_q     <= '0;
      target_q    <= '0;
      error_sum_q <= '0;
      prev_q      <= '0;
      lim_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_beat) begin
        unique case (pidwg_pkg::cfg_reg_e'(cfg_index_i))
          pidwg_pkg::CfgPGain:  pgain_q  <= cfg_data_i;
          pidwg_pkg::CfgIGain: begin
            igain_q   <= cfg_data_i;
            lim_vld_q <= 1'b0;
          end
          pidwg_pkg::CfgDGain:  dgain_q  <= cfg_data_i;
          pidwg_pkg::CfgTarget: target_q <= $signed(cfg_data_i);
        endcase
      end
      if (state_q == pidwg_pkg::StDiv && div_done) begin
        lim_vld_q <= 1'b1;
      end
      if (state_q == pidwg_pkg::StClamp) begin
        error_sum_q <= clamped;
      end
      if (state_q == pidwg_pkg::StDer) begin
        prev_q <= meas_q;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_beat) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      meas_q <= measured_temperature_i;
      err_q  <= err_d;
      sum_q  <= sum_d;
    end
    if (state_q == pidwg_pkg::StDiv && div_done) begin
      lim_q <= div_quot;
    end
    if (load_out) begin
      drive_q <= drive_d;
    end
  end

  pidwg_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .divisor_i (igain_q),
    .busy_o    (div_busy),
    .done_o    (div_done),
    .quot_o    (div_quot)
  );

  pidwg_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (mac_ctl),
    .a_i    (mac_a),
    .b_i    (mac_b),
    .acc_o  (acc)
  );

  assign out_valid_o   = out_valid_q;
  assign drive_value_o = drive_q;

`ifndef SYNTHESIS
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |=> !in_ready_o)
    else $error("input beat taken while a sample is in flight");

  a_div_only_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != pidwg_pkg::StDiv) |-> !div_busy)
    else $error("divider running outside the divide step");

  a_limit_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pidwg_pkg::StClamp && igain_q != '0) |-> lim_vld_q)
    else $error("clamp applied without a valid limit");

  a_sum_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pidwg_pkg::StInt)
      |-> (igain_q == '0 || (error_sum_q <= lim_s && error_sum_q >= neg_lim)))
    else $error("error sum outside the windup limit");

  a_result_from_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q) == pidwg_pkg::StOut)
    else $error("result shown without a finished sample");
`endif

endmodule

`default_nettype wire
